### hdl/hrbd_pkg.sv
// ----------------------------------------------------------------------------
// hrbd_pkg
// types, codes and character constants shared by the body deframer modules
// ----------------------------------------------------------------------------
package hrbd_pkg;

  // input item: one body byte or a connection-closed event
  typedef struct packed {
    logic [7:0] data_byte;
    logic       connection_closed;
  } hrbd_in_t;

  // result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [2:0] status;
  } hrbd_out_t;

  // size line parser decisions and next flag values
  typedef struct packed {
    logic end_line;
    logic fail;
    logic to_trail;
    logic saw_cr;
    logic in_extension;
    logic saw_digit;
  } hrbd_line_t;

  // framing modes
  localparam logic [1:0] MODE_LENGTH = 2'd0;
  localparam logic [1:0] MODE_CHUNKED = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // status codes
  localparam logic [2:0] ST_BUSY = 3'd0;
  localparam logic [2:0] ST_OK = 3'd1;
  localparam logic [2:0] ST_EXCESS = 3'd2;
  localparam logic [2:0] ST_EARLY = 3'd3;
  localparam logic [2:0] ST_BADSIZE = 3'd4;
  localparam logic [2:0] ST_NOFRAME = 3'd5;

  // chunk phases
  localparam logic [1:0] PH_LINE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;

  // configuration register indexes
  localparam logic CFG_FRAMING_MODE = 1'b0;
  localparam logic CFG_CONTENT_LENGTH = 1'b1;

  // characters
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  // hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

### hdl/http_response_body_deframer.sv
// an accepted item passes the input register and then the result register before its result shows
// throughput: one item per cycle; the chunk/length state updates in a single step per byte
// the input stalls only while the result register is full and its consumer stalls
// reset (rst, synchronous, active high) clears both registers, the framing state,
// framing_mode and content_length; the configuration port is always ready
// ----------------------------------------------------------------------------
// http_response_body_deframer
// strips chunked / content-length / until-close framing from a response body
// ----------------------------------------------------------------------------
module http_response_body_deframer import hrbd_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // body bytes and close events
  input  logic        byte_valid,
  output logic        byte_stall,
  input  hrbd_in_t    byte_item,
  // deframed results
  output logic        result_valid,
  input  logic        result_stall,
  output hrbd_out_t   result_item,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [1:0]  framing_mode;
  logic [31:0] content_length;

  // input register
  logic        s1_valid;
  hrbd_in_t    s1_item;

  // step happens when the input register holds an item and the result slot frees up
  logic        advance;
  hrbd_out_t   step_result;

  assign cfg_ready  = 1'b1;
  assign advance    = s1_valid && (!result_valid || !result_stall);
  // only a held result can block the input register
  assign byte_stall = s1_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      framing_mode   <= MODE_LENGTH;
      content_length <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAMING_MODE:   framing_mode   <= cfg_data[1:0];
        CFG_CONTENT_LENGTH: content_length <= cfg_data;
        default:            framing_mode   <= framing_mode;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
  end

  // per-byte framing step
  hrbd_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (s1_item),
    .framing_mode  (framing_mode),
    .content_length(content_length),
    .result        (step_result)
  );

  // result register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result_item <= step_result;
    end
  end

endmodule

### hdl/hrbd_line_parser.sv
// ----------------------------------------------------------------------------
// hrbd_line_parser
// decodes one byte of a hex chunk-size line against the current line state
// ----------------------------------------------------------------------------
module hrbd_line_parser import hrbd_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic [7:0]             data_byte,
  input  logic                   trail_phase,
  input  logic [COUNT_WIDTH-1:0] size_accum,
  input  logic                   saw_cr,
  input  logic                   in_extension,
  input  logic                   saw_digit,
  output hrbd_line_t             line,
  output logic [COUNT_WIDTH-1:0] size_accum_next
);

  logic [4:0] hex;

  assign hex = hex_value(data_byte);

  always_comb begin
    line.end_line     = 1'b0;
    line.fail         = 1'b0;
    line.to_trail     = 1'b0;
    line.saw_cr       = saw_cr;
    line.in_extension = in_extension;
    line.saw_digit    = saw_digit;
    size_accum_next   = size_accum;
    if (in_extension) begin
      if (saw_cr && data_byte == CH_LF) begin
        line.end_line = 1'b1;
      end else begin
        line.saw_cr = (data_byte == CH_CR);
      end
    end else if (saw_cr) begin
      if (data_byte == CH_LF) begin
        line.end_line = 1'b1;
      end else begin
        line.fail = 1'b1;
      end
    end else if (data_byte == CH_CR) begin
      if (saw_digit) begin
        line.saw_cr = 1'b1;
      end
    end else if (data_byte == CH_LF) begin
      line.fail = saw_digit;
    end else if (data_byte == CH_SP || data_byte == CH_TAB) begin
      line.to_trail = saw_digit;
    end else if (data_byte == CH_SEMI) begin
      if (!saw_digit) begin
        line.fail = 1'b1;
      end else begin
        line.in_extension = 1'b1;
      end
    end else if (!hex[4] || trail_phase) begin
      line.fail = 1'b1;
    end else if (|size_accum[COUNT_WIDTH-1:COUNT_WIDTH-4]) begin
      // another digit would overflow the counter
      line.fail = 1'b1;
    end else begin
      size_accum_next = {size_accum[COUNT_WIDTH-5:0], hex[3:0]};
      line.saw_digit  = 1'b1;
    end
  end

endmodule

### hdl/hrbd_core.sv
// ----------------------------------------------------------------------------
// hrbd_core
// deframing state and the per-item step logic
// ----------------------------------------------------------------------------
module hrbd_core import hrbd_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  hrbd_in_t    item,
  input  logic [1:0]  framing_mode,
  input  logic [31:0] content_length,
  output hrbd_out_t   result
);

  localparam logic [63:0] CountMask = {64{1'b1}} >> (64 - COUNT_WIDTH);
  localparam logic [COUNT_WIDTH-1:0] One = COUNT_WIDTH'(1);

  logic [1:0]             phase, phase_next, ph;
  logic [COUNT_WIDTH-1:0] size_accum, size_accum_next, parsed_accum;
  logic [COUNT_WIDTH-1:0] remaining_count, remaining_count_next, rc, cl_sat;
  logic                   saw_cr, saw_cr_next;
  logic                   in_extension, in_extension_next;
  logic                   saw_digit, saw_digit_next;
  logic                   finished, finished_next;
  logic                   remaining_loaded;
  logic [2:0]             final_status, final_status_next;
  logic [63:0]            cl_wide;
  hrbd_line_t             line;

  assign cl_wide = {32'd0, content_length};
  assign cl_sat  = (cl_wide > CountMask) ? CountMask[COUNT_WIDTH-1:0]
                                         : cl_wide[COUNT_WIDTH-1:0];
  assign rc      = remaining_loaded ? remaining_count : cl_sat;
  assign ph      = (phase == PH_DATA && rc == '0) ? PH_LINE : phase;

  hrbd_line_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_line_parser (
    .data_byte      (item.data_byte),
    .trail_phase    (ph == PH_TRAIL),
    .size_accum     (size_accum),
    .saw_cr         (saw_cr),
    .in_extension   (in_extension),
    .saw_digit      (saw_digit),
    .line           (line),
    .size_accum_next(parsed_accum)
  );

  always_comb begin
    phase_next           = phase;
    size_accum_next      = size_accum;
    remaining_count_next = rc;
    saw_cr_next          = saw_cr;
    in_extension_next    = in_extension;
    saw_digit_next       = saw_digit;
    finished_next        = finished;
    final_status_next    = final_status;
    result.payload_byte  = 8'd0;
    result.payload_valid = 1'b0;
    result.status        = ST_BUSY;

    if (finished) begin
      if (!item.connection_closed && framing_mode == MODE_LENGTH && final_status == ST_OK) begin
        final_status_next = ST_EXCESS;
      end
      result.status = final_status_next;
    end else if (item.connection_closed) begin
      finished_next = 1'b1;
      case (framing_mode)
        MODE_CLOSE:  final_status_next = ST_OK;
        MODE_NONE:   final_status_next = ST_NOFRAME;
        MODE_LENGTH: final_status_next = (rc == '0) ? ST_OK : ST_EARLY;
        default:     final_status_next = ST_EARLY;
      endcase
      result.status = final_status_next;
    end else if (framing_mode == MODE_LENGTH) begin
      if (rc == '0) begin
        finished_next     = 1'b1;
        final_status_next = ST_EXCESS;
        result.status     = ST_EXCESS;
      end else begin
        result.payload_valid = 1'b1;
        remaining_count_next = rc - One;
        if (rc == One) begin
          finished_next     = 1'b1;
          final_status_next = ST_OK;
          result.status     = ST_OK;
        end
      end
    end else if (framing_mode == MODE_CLOSE) begin
      result.payload_valid = 1'b1;
    end else if (framing_mode == MODE_NONE) begin
      finished_next     = 1'b1;
      final_status_next = ST_NOFRAME;
      result.status     = ST_NOFRAME;
    end else begin
      phase_next = ph;
      if (ph == PH_DATA) begin
        result.payload_valid = 1'b1;
        remaining_count_next = rc - One;
        if (rc == One) begin
          phase_next        = PH_LINE;
          size_accum_next   = '0;
          saw_cr_next       = 1'b0;
          in_extension_next = 1'b0;
          saw_digit_next    = 1'b0;
        end
      end else if (line.fail) begin
        finished_next     = 1'b1;
        final_status_next = ST_BADSIZE;
        result.status     = ST_BADSIZE;
      end else if (line.end_line) begin
        size_accum_next   = '0;
        saw_cr_next       = 1'b0;
        in_extension_next = 1'b0;
        saw_digit_next    = 1'b0;
        if (size_accum == '0) begin
          finished_next     = 1'b1;
          final_status_next = ST_OK;
          result.status     = ST_OK;
        end else begin
          remaining_count_next = size_accum;
          phase_next           = PH_DATA;
        end
      end else begin
        size_accum_next   = parsed_accum;
        saw_cr_next       = line.saw_cr;
        in_extension_next = line.in_extension;
        saw_digit_next    = line.saw_digit;
        if (line.to_trail) begin
          phase_next = PH_TRAIL;
        end
      end
    end

    if (result.payload_valid) begin
      result.payload_byte = item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LINE;
      size_accum       <= '0;
      remaining_count  <= '0;
      saw_cr           <= 1'b0;
      in_extension     <= 1'b0;
      saw_digit        <= 1'b0;
      finished         <= 1'b0;
      remaining_loaded <= 1'b0;
      final_status     <= ST_BUSY;
    end else if (step) begin
      phase            <= phase_next;
      size_accum       <= size_accum_next;
      remaining_count  <= remaining_count_next;
      saw_cr           <= saw_cr_next;
      in_extension     <= in_extension_next;
      saw_digit        <= saw_digit_next;
      finished         <= finished_next;
      remaining_loaded <= 1'b1;
      final_status     <= final_status_next;
    end
  end

endmodule

### hdl/hrbd_checker.sv
// ----------------------------------------------------------------------------
// hrbd_checker
// port-level checks on the deframer result stream and flow control
// ----------------------------------------------------------------------------
module hrbd_checker import hrbd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_stall,
  input logic      result_valid,
  input logic      result_stall,
  input hrbd_out_t result_item
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // payload only while the body is in progress or just completed
  a_payload_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.payload_valid |->
      result_item.status == ST_BUSY || result_item.status == ST_OK)
    else $error("payload with a failure status");

  // no byte leaks out when nothing is delivered
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.payload_valid |-> result_item.payload_byte == 8'd0)
    else $error("payload byte set without payload_valid");

  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall)
    else $error("input stalled with a free result slot");

endmodule

bind http_response_body_deframer hrbd_checker u_hrbd_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_stall  (byte_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_item (result_item)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives http_response_body_deframer with body bytes in all framing modes,
// predicts every result item and compares it field by field as it arrives
// ----------------------------------------------------------------------------
module testbench;
  import hrbd_pkg::*;

  // tracks the deframer state and holds the result items still owed
  class deframe_tracker;
    logic [1:0]  mode_reg = MODE_LENGTH;
    logic [31:0] length_reg = '0;
    logic [1:0]  stage = PH_LINE;
    logic [31:0] size_sum = '0;
    logic [31:0] bytes_left = '0;
    bit          cr_seen = 1'b0;
    bit          in_ext = 1'b0;
    bit          digit_seen = 1'b0;
    bit          ended = 1'b0;
    bit          left_loaded = 1'b0;
    logic [2:0]  end_code = ST_BUSY;
    hrbd_out_t   owed[$];
    int          faults = 0;

    function void write_reg(input logic idx, input logic [31:0] val);
      if (idx == CFG_FRAMING_MODE) begin
        mode_reg = val[1:0];
      end else begin
        length_reg = val;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function logic [2:0] conclude(input logic [2:0] code);
      ended = 1'b1;
      end_code = code;
      return code;
    endfunction

    function void clear_line();
      size_sum = '0;
      cr_seen = 1'b0;
      in_ext = 1'b0;
      digit_seen = 1'b0;
    endfunction

    // crlf at the end of a size line: zero ends the body, else data follows
    function logic [2:0] close_line();
      logic [31:0] sz;
      sz = size_sum;
      clear_line();
      if (sz == 0) return conclude(ST_OK);
      bytes_left = sz;
      stage = PH_DATA;
      return ST_BUSY;
    endfunction

    function void accept_item(input hrbd_in_t it);
      hrbd_out_t  r;
      logic [7:0] b;
      logic [2:0] st;
      logic [4:0] nib;
      r = '0;
      st = ST_BUSY;
      b = it.data_byte;
      if (!left_loaded) begin
        bytes_left = length_reg;
        left_loaded = 1'b1;
      end
      if (ended) begin
        if (!it.connection_closed && mode_reg == MODE_LENGTH && end_code == ST_OK)
          end_code = ST_EXCESS;
        st = end_code;
      end else if (it.connection_closed) begin
        if (mode_reg == MODE_CLOSE) st = conclude(ST_OK);
        else if (mode_reg == MODE_NONE) st = conclude(ST_NOFRAME);
        else if (mode_reg == MODE_LENGTH && bytes_left == 0) st = conclude(ST_OK);
        else st = conclude(ST_EARLY);
      end else if (mode_reg == MODE_LENGTH) begin
        if (bytes_left == 0) begin
          st = conclude(ST_EXCESS);
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          bytes_left = bytes_left - 1;
          if (bytes_left == 0) st = conclude(ST_OK);
        end
      end else if (mode_reg == MODE_CLOSE) begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
      end else if (mode_reg == MODE_NONE) begin
        st = conclude(ST_NOFRAME);
      end else begin
        if (stage == PH_DATA && bytes_left == 0) stage = PH_LINE;
        if (stage == PH_DATA) begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          bytes_left = bytes_left - 1;
          if (bytes_left == 0) begin
            stage = PH_LINE;
            clear_line();
          end
        end else if (in_ext) begin
          if (cr_seen && b == CH_LF) st = close_line();
          else cr_seen = (b == CH_CR);
        end else if (cr_seen) begin
          st = (b == CH_LF) ? close_line() : conclude(ST_BADSIZE);
        end else if (b == CH_CR) begin
          if (digit_seen) cr_seen = 1'b1;
        end else if (b == CH_LF) begin
          if (digit_seen) st = conclude(ST_BADSIZE);
        end else if (b == CH_SP || b == CH_TAB) begin
          if (digit_seen) stage = PH_TRAIL;
        end else if (b == CH_SEMI) begin
          if (!digit_seen) st = conclude(ST_BADSIZE);
          else in_ext = 1'b1;
        end else begin
          nib = '0;
          if (b >= "0" && b <= "9") nib = {1'b1, b[3:0]};
          else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f"))
            nib = {1'b1, b[3:0] + 4'd9};
          if (!nib[4] || stage == PH_TRAIL || size_sum[31:28] != 0) begin
            st = conclude(ST_BADSIZE);
          end else begin
            size_sum = {size_sum[27:0], nib[3:0]};
            digit_seen = 1'b1;
          end
        end
      end
      r.status = st;
      owed = {owed, r};
    endfunction

    function void compare_result(input hrbd_out_t got);
      hrbd_out_t want;
      if (owed.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result with nothing owed: byte %h valid %b status %0d",
                   got.payload_byte, got.payload_valid, got.status);
        return;
      end
      want = owed.pop_front();
      if (got.payload_byte !== want.payload_byte || got.payload_valid !== want.payload_valid ||
          got.status !== want.status) begin
        faults++;
        if (faults <= 10)
          $display("mismatch: expected byte %h valid %b status %0d, got byte %h valid %b status %0d",
                   want.payload_byte, want.payload_valid, want.status,
                   got.payload_byte, got.payload_valid, got.status);
      end
    endfunction
  endclass

  // how the run is brought to its end once the random part is over
  typedef enum int {
    END_ZERO_CHUNK, END_BAD_CHAR, END_TRAIL_DIGIT, END_OVERFLOW, END_EARLY_CLOSE,
    END_CLOSE_DONE, END_NO_FRAMING, END_LENGTH_DONE, END_LINE_BREAK, END_LENGTH_ZERO
  } ending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  hrbd_in_t    byte_item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  hrbd_out_t   result_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FRAMING_MODE;
  logic [31:0] cfg_data = '0;

  deframe_tracker tracker = new();
  bit gaps_on = 1'b1;     // random idling on both sides
  int item_count = 0;     // input items sent
  int stall_run = 0;

  http_response_body_deframer dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: check every accepted result item at the rising edge
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) tracker.compare_result(result_item);
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      result_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_run <= $urandom_range(0, 2);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // offer one item from a falling edge and hold it until accepted;
  // valid stays up on return so back-to-back items need no second assignment
  task automatic put_item(input logic [7:0] b, input logic closed);
    hrbd_in_t it;
    it.data_byte = b;
    it.connection_closed = closed;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    tracker.accept_item(it);
    item_count++;
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_item(b, 1'b0);
  endtask

  // a blank the size line parser skips
  task automatic put_blank(input logic [7:0] b);
    put_item(b, 1'b0);
  endtask

  task automatic put_close();
    put_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_data(input int n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_SP;
      default: return CH_TAB;
    endcase
  endfunction

  // any byte that is neither a hex digit nor one the size line treats specially
  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f") ||
               b == CH_CR || b == CH_LF || b == CH_SP || b == CH_TAB || b == CH_SEMI);
    return b;
  endfunction

  // wait for the pipe to drain, then write both registers
  task automatic set_framing(input logic [1:0] mode, input logic [31:0] len);
    byte_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    // two register stages behind the last result
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FRAMING_MODE;
    cfg_data <= {30'd0, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(CFG_FRAMING_MODE, {30'd0, mode});
    @(negedge clk);
    cfg_index <= CFG_CONTENT_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(CFG_CONTENT_LENGTH, len);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // chunk size line: optional leading blanks and zeros, mixed-case hex,
  // optional trailing blank and extension with random content, then crlf
  task automatic send_size_line(input logic [31:0] len);
    int         digits;
    logic [3:0] nib;
    logic [7:0] ch;
    digits = 1;
    for (int k = 1; k < 8; k++) if ((len >> (4 * k)) != 0) digits = k + 1;
    repeat ($urandom_range(0, 2)) put_blank(pick_blank());
    repeat ($urandom_range(0, 1)) put_byte("0");
    for (int k = digits - 1; k >= 0; k--) begin
      nib = len[4 * k +: 4];
      if (nib < 4'd10) ch = "0" + nib;
      else ch = ($urandom_range(0, 1) ? "a" : "A") + nib - 4'd10;
      put_byte(ch);
    end
    repeat ($urandom_range(0, 1)) put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    if ($urandom_range(0, 2) == 0) begin
      put_byte(CH_SEMI);
      // extension text, anything but a line feed
      repeat ($urandom_range(0, 4)) begin
        do ch = 8'($urandom_range(0, 255)); while (ch == CH_LF);
        put_byte(ch);
      end
    end
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  // once the body has ended every mode repeats the final status, but a byte in length mode turns ok into excess
  task automatic poke_after_end(input logic [1:0] mode);
    set_framing(mode, 32'($urandom));
    put_byte(8'($urandom_range(0, 255)));
    put_close();
    put_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    ending_t ending;
    int      chunk_len;
    int      part;
    int      skip;
    int      guard;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: widest length loaded on the first item, byte extremes
    set_framing(MODE_LENGTH, 32'hFFFF_FFFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    set_framing(MODE_CLOSE, 32'h0);
    put_byte(8'hFF);
    put_byte(8'h00);
    // chunked: leading blanks, trailing blank, extension ending in crlf
    set_framing(MODE_CHUNKED, 32'h0);
    put_blank(CH_CR);
    put_blank(CH_LF);
    put_blank(CH_SP);
    put_blank(CH_TAB);
    put_byte("2");
    put_byte(CH_SP);
    put_byte(CH_SEMI);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_blank(CH_CR);
    put_blank(CH_LF);

    // random: mostly well-formed chunks, some mode hops inside the data,
    // raw byte stretches in until-close mode and runs of skipped blanks
    while (item_count < 740) begin
      if (item_count > 660) gaps_on = 1'b0;
      else if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
      case ($urandom_range(0, 9))
        0: begin
          set_framing(MODE_CLOSE, 32'($urandom));
          send_data($urandom_range(4, 20));
          set_framing(MODE_CHUNKED, 32'($urandom));
        end
        1: repeat ($urandom_range(1, 4)) put_blank(pick_blank());
        default: begin
          chunk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
          send_size_line(chunk_len);
          if ($urandom_range(0, 4) == 0) begin
            part = $urandom_range(0, chunk_len - 1);
            send_data(part);
            if ($urandom_range(0, 1)) begin
              // length mode shares the counter; keep at least one byte for chunked
              skip = $urandom_range(0, chunk_len - part - 1);
              set_framing(MODE_LENGTH, 32'($urandom));
              send_data(skip);
              set_framing(MODE_CHUNKED, 32'($urandom));
              send_data(chunk_len - part - skip);
            end else begin
              set_framing(MODE_CLOSE, 32'($urandom));
              send_data($urandom_range(1, 6));
              set_framing(MODE_CHUNKED, 32'($urandom));
              send_data(chunk_len - part);
            end
          end else begin
            send_data(chunk_len);
          end
          put_blank(CH_CR);
          put_blank(CH_LF);
        end
      endcase
    end

    // one way of ending the body, then items after the end in every mode
    gaps_on = 1'b0;
    ending = ending_t'($urandom_range(0, 9));
    case (ending)
      END_ZERO_CHUNK: send_size_line(32'h0);
      END_BAD_CHAR: begin
        if ($urandom_range(0, 1)) put_byte("1");
        put_byte(pick_junk());
      end
      END_TRAIL_DIGIT: begin
        put_byte("1");
        put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
        put_byte("2");
      end
      // nine digits no longer fit the counter
      END_OVERFLOW: repeat (9) put_byte("f");
      END_EARLY_CLOSE: begin
        send_size_line($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(2, 16)));
        send_data($urandom_range(0, 1));
        put_close();
      end
      END_CLOSE_DONE: begin
        set_framing(MODE_CLOSE, 32'hFFFF_FFFF);
        send_data(3);
        put_close();
      end
      END_NO_FRAMING: begin
        set_framing(MODE_NONE, 32'h0);
        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
        else put_close();
      end
      END_LENGTH_DONE: begin
        chunk_len = $urandom_range(1, 16);
        send_size_line(chunk_len);
        part = $urandom_range(0, chunk_len - 1);
        send_data(part);
        set_framing(MODE_LENGTH, 32'h0);
        send_data(chunk_len - part);
      end
      END_LINE_BREAK: begin
        case ($urandom_range(0, 2))
          0: put_byte(CH_SEMI);
          1: begin
            put_byte("3");
            put_byte(CH_LF);
          end
          default: begin
            put_byte("3");
            put_byte(CH_CR);
            put_byte(pick_junk());
          end
        endcase
      end
      default: begin
        // counter already at zero: a byte is too much, a close is a clean end
        set_framing(MODE_LENGTH, 32'h0);
        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
        else put_close();
      end
    endcase
    poke_after_end(MODE_CHUNKED);
    poke_after_end(MODE_CLOSE);
    poke_after_end(MODE_NONE);
    poke_after_end(MODE_LENGTH);

    byte_valid <= 1'b0;
    for (guard = 0; guard < 1000 && tracker.pending() != 0; guard++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (tracker.pending() == 0 && tracker.faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### http_response_body_deframer.f
hdl/hrbd_pkg.sv
hdl/hrbd_line_parser.sv
hdl/hrbd_core.sv
hdl/http_response_body_deframer.sv
hdl/hrbd_checker.sv
test/testbench.sv
